### sv/slhc_pkg.sv
package slhc_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_BASE  = 2'd1;
   localparam logic [1:0] KIND_PULSE = 2'd2;

   localparam logic [2:0] BASE_BOOT         = 3'd0;
   localparam logic [2:0] BASE_FORMING      = 3'd1;
   localparam logic [2:0] BASE_READY_CLOSED = 3'd2;
   localparam logic [2:0] BASE_READY_OPEN   = 3'd3;

   localparam logic [1:0] PULSE_NETWORK = 2'd0;
   localparam logic [1:0] PULSE_EVENT   = 2'd1;

   localparam logic CSR_HB_PERIOD  = 1'b0;
   localparam logic CSR_PULSE_DUR  = 1'b1;

   localparam logic [15:0] HB_PERIOD_RESET = 16'd2200;
   localparam logic [15:0] PULSE_DUR_RESET = 16'd120;

   localparam int PhaseW = 16;
   localparam int IdxW   = 5;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PhaseW-1:0] remainder;
      logic [IdxW-1:0]   index;
   } div_status_type;

   typedef struct packed {
      logic [7:0] green;
      logic [7:0] blue;
   } hb_color_type;

   function automatic hb_color_type hb_color(logic [IdxW-1:0] idx);
      logic [IdxW-1:0] level;
      hb_color_type    c;
      level = (idx[4] && (idx[3:0] != 4'd0)) ? (5'd0 - idx) : idx;
      unique case (level)
         5'd0:    c = '{green: 8'd26, blue: 8'd0};
         5'd1:    c = '{green: 8'd26, blue: 8'd0};
         5'd2:    c = '{green: 8'd25, blue: 8'd1};
         5'd3:    c = '{green: 8'd24, blue: 8'd2};
         5'd4:    c = '{green: 8'd23, blue: 8'd4};
         5'd5:    c = '{green: 8'd21, blue: 8'd6};
         5'd6:    c = '{green: 8'd19, blue: 8'd8};
         5'd7:    c = '{green: 8'd17, blue: 8'd11};
         5'd8:    c = '{green: 8'd15, blue: 8'd14};
         5'd9:    c = '{green: 8'd13, blue: 8'd17};
         5'd10:   c = '{green: 8'd10, blue: 8'd19};
         5'd11:   c = '{green: 8'd8,  blue: 8'd22};
         5'd12:   c = '{green: 8'd7,  blue: 8'd24};
         5'd13:   c = '{green: 8'd5,  blue: 8'd27};
         5'd14:   c = '{green: 8'd3,  blue: 8'd28};
         5'd15:   c = '{green: 8'd2,  blue: 8'd29};
         5'd16:   c = '{green: 8'd2,  blue: 8'd30};
         default: c = '{green: 8'd26, blue: 8'd0};
      endcase
      return c;
   endfunction

endpackage

### sv/slhc_div.sv
module slhc_div
   import slhc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PhaseW-1:0]   dividend,
   input  logic [PhaseW-1:0]   divisor,
   output div_status_type      status
);

   localparam int Steps   = PhaseW + IdxW;
   localparam int CntW    = $clog2(Steps);
   localparam int ModStep = PhaseW - 1;

   logic                busy_ff;
   logic                done_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [PhaseW-1:0]   rem_ff;
   logic [PhaseW-1:0]   rem_in;
   logic [Steps-1:0]    dvd_ff;
   logic [PhaseW-1:0]   div_ff;
   logic [IdxW-1:0]     quo_ff;
   logic [PhaseW-1:0]   mod_ff;
   logic [PhaseW:0]     trial;
   logic [PhaseW:0]     diff;
   logic                fits;

   assign trial  = {rem_ff, dvd_ff[Steps-1]};
   assign fits   = trial >= {1'b0, div_ff};
   assign diff   = trial - {1'b0, div_ff};
   assign rem_in = fits ? diff[PhaseW-1:0] : trial[PhaseW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dvd_ff  <= {dividend, {IdxW{1'b0}}};
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[Steps-2:0], 1'b0};
            quo_ff <= {quo_ff[IdxW-2:0], fits};
            cnt_ff <= cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(ModStep)) begin
               mod_ff <= rem_in;
            end
            if (cnt_ff == CntW'(Steps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status = '{busy: busy_ff, done: done_ff, remainder: mod_ff, index: quo_ff};

endmodule

### sv/slhc_color.sv
module slhc_color
   import slhc_pkg::*;
(
   input  logic [2:0]      base,
   input  logic [IdxW-1:0] idx,
   input  logic            pulse_on,
   input  logic [6:0]      pulse_red,
   input  logic [6:0]      pulse_green,
   input  logic [6:0]      pulse_blue,
   output logic [7:0]      red,
   output logic [7:0]      green,
   output logic [7:0]      blue
);

   function automatic logic [7:0] sat_add(logic [7:0] a, logic [6:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {2'b00, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   hb_color_type hb;
   logic [7:0]   base_r;
   logic [7:0]   base_g;
   logic [7:0]   base_b;

   assign hb = hb_color(idx);

   always_comb begin
      unique case (base)
         BASE_BOOT:         {base_r, base_g, base_b} = {8'd0,  8'd0,     8'd18};
         BASE_FORMING:      {base_r, base_g, base_b} = {8'd0,  8'd18,    8'd18};
         BASE_READY_CLOSED: {base_r, base_g, base_b} = {8'd0,  hb.green, hb.blue};
         BASE_READY_OPEN:   {base_r, base_g, base_b} = {8'd18, 8'd10,    8'd0};
         default:           {base_r, base_g, base_b} = {8'd18, 8'd0,     8'd0};
      endcase
   end

   assign red   = pulse_on ? sat_add(base_r, pulse_red)   : base_r;
   assign green = pulse_on ? sat_add(base_g, pulse_green) : base_g;
   assign blue  = pulse_on ? sat_add(base_b, pulse_blue)  : base_b;

endmodule

### sv/status_led_heartbeat_color.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | req_kind, req_base_state, req_pulse_kind
// rsp     | out       | rsp_valid/rsp_stall  | rsp_red, rsp_green, rsp_blue
// csr     | in        | csr_write            | csr_index, csr_data
//
// Outside ready closed an accepted request goes to the output step and loads its result there.
// In ready closed a bit-serial divider forms phase mod period and the table index,
// one quotient bit a cycle; the result loads in the output step once the divider is done.
// One request at a time; the next is taken while a result waits.
// Synchronous reset restores the register defaults and the boot state.
// A stalled result holds; the block waits in its output step until the register frees.
module status_led_heartbeat_color
   import slhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_base_state,
   input  logic [1:0]  req_pulse_kind,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUT} state_type;

   state_type         state_ff;
   logic [15:0]       period_ff;
   logic [15:0]       duration_ff;
   logic [2:0]        base_ff;
   logic [2:0]        base_in;
   logic [PhaseW-1:0] phase_ff;
   logic [PhaseW-1:0] phase_in;
   logic [15:0]       pulse_left_ff;
   logic [15:0]       pulse_left_in;
   logic [6:0]        pulse_red_ff;
   logic [6:0]        pulse_green_ff;
   logic [6:0]        pulse_blue_ff;
   logic [IdxW-1:0]   idx_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_red_ff;
   logic [7:0]        rsp_green_ff;
   logic [7:0]        rsp_blue_ff;
   logic              accept;
   logic              load_ok;
   logic              div_start;
   logic [15:0]       per_eff;
   logic [7:0]        col_r;
   logic [7:0]        col_g;
   logic [7:0]        col_b;
   div_status_type    div_status;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign per_eff   = (period_ff == 16'd0) ? 16'd1 : period_ff;

   always_comb begin
      base_in       = (req_kind == KIND_BASE) ? req_base_state : base_ff;
      phase_in      = (req_kind == KIND_TICK) ? phase_ff + PhaseW'(1) : phase_ff;
      pulse_left_in = pulse_left_ff;
      if (req_kind == KIND_TICK && pulse_left_ff != 16'd0) begin
         pulse_left_in = pulse_left_ff - 16'd1;
      end else if (req_kind == KIND_PULSE) begin
         pulse_left_in = duration_ff;
      end
      if (base_in != BASE_READY_CLOSED) begin
         phase_in = '0;
      end
   end

   assign div_start = accept && (base_in == BASE_READY_CLOSED);

   slhc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (phase_in),
      .divisor  (per_eff),
      .status   (div_status)
   );

   slhc_color u_color (
      .base        (base_ff),
      .idx         (idx_ff),
      .pulse_on    (pulse_left_ff != 16'd0),
      .pulse_red   (pulse_red_ff),
      .pulse_green (pulse_green_ff),
      .pulse_blue  (pulse_blue_ff),
      .red         (col_r),
      .green       (col_g),
      .blue        (col_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         period_ff      <= HB_PERIOD_RESET;
         duration_ff    <= PULSE_DUR_RESET;
         base_ff        <= BASE_BOOT;
         phase_ff       <= '0;
         pulse_left_ff  <= '0;
         pulse_red_ff   <= '0;
         pulse_green_ff <= '0;
         pulse_blue_ff  <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_HB_PERIOD: period_ff   <= csr_data;
               CSR_PULSE_DUR: duration_ff <= csr_data;
               default:       period_ff   <= period_ff;
            endcase
         end
         if (!rsp_stall && state_ff != ST_PUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  base_ff       <= base_in;
                  phase_ff      <= phase_in;
                  pulse_left_ff <= pulse_left_in;
                  if (req_kind == KIND_PULSE) begin
                     unique case (req_pulse_kind)
                        PULSE_NETWORK: begin
                           {pulse_red_ff, pulse_green_ff, pulse_blue_ff} <=
                              {7'd0, 7'd0, 7'd80};
                        end
                        PULSE_EVENT: begin
                           {pulse_red_ff, pulse_green_ff, pulse_blue_ff} <=
                              {7'd80, 7'd80, 7'd80};
                        end
                        default: begin
                           {pulse_red_ff, pulse_green_ff, pulse_blue_ff} <=
                              {7'd60, 7'd0, 7'd70};
                        end
                     endcase
                  end
                  state_ff <= div_start ? ST_DIV : ST_PUT;
               end
            end
            ST_DIV: begin
               if (div_status.done) begin
                  phase_ff <= div_status.remainder;
                  idx_ff   <= div_status.index;
                  state_ff <= ST_PUT;
               end
            end
            ST_PUT: begin
               if (load_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_red_ff   <= col_r;
                  rsp_green_ff <= col_g;
                  rsp_blue_ff  <= col_b;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

   a_phase_zero_off_wave: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT && base_ff != BASE_READY_CLOSED) |-> phase_ff == '0)
      else $error("phase not cleared outside ready closed");

   a_phase_below_period: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT && base_ff == BASE_READY_CLOSED) |-> phase_ff < per_eff)
      else $error("phase not reduced below period");

   a_stall_while_div: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (req_stall && state_ff == ST_DIV))
      else $error("divider busy outside divide step");

endmodule
